[hw/rtl/obrb_pkg.sv]
package obrb_pkg;

  // Fixed field widths
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned FILL_W     = 9;
  localparam int unsigned ACTION_W   = 2;
  localparam int unsigned IN_TDATA_W  = 16;
  localparam int unsigned OUT_TDATA_W = 24;
  localparam int unsigned OUT_TUSER_W = 2;

  // Default buffer depth in bytes
  localparam int unsigned CAPACITY_DEF = 256;

  typedef logic [BYTE_W-1:0] byte_t;

  typedef enum logic [ACTION_W-1:0] {
    ACT_PUT  = 2'd0,
    ACT_GET  = 2'd1,
    ACT_PEEK = 2'd2
  } action_t;

endpackage

[hw/rtl/overwriting_byte_ring_buffer_top.sv]
// Byte ring buffer that drops its oldest byte when a put finds it full. Each
// input transfer carries one operation in in_tuser (put, get or peek) and
// yields exactly one output transfer, via the read stage and output register:
// the byte read, a valid flag, an overwrite flag and the fill level after the
// operation. The block takes one transfer per clock cycle as long as results
// are taken; a stalled result holds the read stage and with it the input. The
// byte memory has one write port and one registered read port and does one
// write or one read per operation. Pointers and the fill count live in
// flip-flops and are updated at the transfer, so back-to-back operations see
// each other's effect. The memory needs no clearing: only written bytes are
// ever returned. Reaching an empty buffer through a get returns both
// pointers to zero.
module overwriting_byte_ring_buffer_top #(
  parameter int unsigned CAPACITY = obrb_pkg::CAPACITY_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // in_tdata: [7:0] data_in, [15:8] peek_index
  input  logic [obrb_pkg::IN_TDATA_W-1:0]     in_tdata,
  // in_tuser: [1:0] action
  input  logic [obrb_pkg::ACTION_W-1:0]       in_tuser,
  input  logic                                in_tlast,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // out_tdata: [7:0] data_out, [16:8] fill_level, [23:17] zero
  output logic [obrb_pkg::OUT_TDATA_W-1:0]    out_tdata,
  // out_tuser: [0] valid_res, [1] overwrote
  output logic [obrb_pkg::OUT_TUSER_W-1:0]    out_tuser,
  output logic                                out_tlast,
  output logic                                out_tvalid,
  input  logic                                out_tready
);
  import obrb_pkg::*;

  localparam int unsigned PW   = $clog2(CAPACITY);
  localparam int unsigned CW   = $clog2(CAPACITY + 1);
  localparam int unsigned SUMW = PW + 9;
  localparam int unsigned CMPW = CW + 9;

  // Pointer and count state
  logic [PW-1:0] rp_r, rp_nxt;
  logic [PW-1:0] wp_r, wp_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  // Read stage: memory read in flight
  logic          s1_valid_r;
  logic          s1_rd_r;
  logic          s1_over_r;
  logic          s1_last_r;
  logic [CW-1:0] s1_cnt_r;

  // Output register
  logic          out_valid_r;
  byte_t         out_data_r;
  logic          out_vres_r;
  logic          out_over_r;
  logic          out_last_r;
  logic [FILL_W-1:0] out_fill_r;

  logic          in_acc;
  logic          s1_move;
  action_t       action;
  byte_t         data_in;
  byte_t         peek_idx;

  logic          mem_we;
  logic          mem_re;
  logic [PW-1:0] mem_raddr;
  byte_t         mem_q;
  logic          rd_hit;
  logic          over;

  logic [SUMW-1:0] pos_sum;
  logic [PW-1:0]   peek_pos;

  assign action   = action_t'(in_tuser);
  assign data_in  = in_tdata[7:0];
  assign peek_idx = in_tdata[15:8];

  assign s1_move   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_move;
  assign in_acc    = in_tvalid && in_tready;

  // Peek address, wrapped with one compare and subtract
  always_comb begin
    pos_sum = SUMW'(rp_r) + SUMW'(peek_idx);
    if (pos_sum >= SUMW'(CAPACITY)) begin
      pos_sum = pos_sum - SUMW'(CAPACITY);
    end
    peek_pos = pos_sum[PW-1:0];
  end

  // Decode the operation and compute the next pointers
  always_comb begin
    rp_nxt    = rp_r;
    wp_nxt    = wp_r;
    cnt_nxt   = cnt_r;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_raddr = rp_r;
    rd_hit    = 1'b0;
    over      = 1'b0;
    case (action)
      ACT_PUT: begin
        mem_we = in_acc;
        wp_nxt = (wp_r == PW'(CAPACITY - 1)) ? '0 : wp_r + 1'b1;
        if (cnt_r == CW'(CAPACITY)) begin
          rp_nxt = (rp_r == PW'(CAPACITY - 1)) ? '0 : rp_r + 1'b1;
          over   = 1'b1;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ACT_GET: begin
        if (cnt_r != '0) begin
          rd_hit    = 1'b1;
          mem_re    = in_acc;
          mem_raddr = rp_r;
          cnt_nxt   = cnt_r - 1'b1;
          if (cnt_r == CW'(1)) begin
            rp_nxt = '0;
            wp_nxt = '0;
          end else begin
            rp_nxt = (rp_r == PW'(CAPACITY - 1)) ? '0 : rp_r + 1'b1;
          end
        end
      end
      ACT_PEEK: begin
        if (CMPW'(peek_idx) < CMPW'(cnt_r)) begin
          rd_hit    = 1'b1;
          mem_re    = in_acc;
          mem_raddr = peek_pos;
        end
      end
      default: begin
        rd_hit = 1'b0;
      end
    endcase
  end

  obrb_store #(
    .DEPTH (CAPACITY)
  ) u_store (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (wp_r),
    .wr_data (data_in),
    .rd_en   (mem_re),
    .rd_addr (mem_raddr),
    .rd_data (mem_q)
  );

  // Advance pointers and the read stage on an input transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rp_r       <= '0;
      wp_r       <= '0;
      cnt_r      <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        rp_r  <= rp_nxt;
        wp_r  <= wp_nxt;
        cnt_r <= cnt_nxt;
      end
      if (in_acc) begin
        s1_valid_r <= 1'b1;
      end else if (s1_move) begin
        s1_valid_r <= 1'b0;
      end
    end
  end

  // Read stage payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_rd_r   <= rd_hit;
      s1_over_r <= over;
      s1_last_r <= in_tlast;
      s1_cnt_r  <= cnt_nxt;
    end
  end

  // Output register: load from the read stage, drop on transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_move) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_data_r <= s1_rd_r ? mem_q : '0;
      out_vres_r <= s1_rd_r;
      out_over_r <= s1_over_r;
      out_last_r <= s1_last_r;
      out_fill_r <= FILL_W'(s1_cnt_r);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_fill_r, out_data_r};
  assign out_tuser  = {out_over_r, out_vres_r};
  assign out_tlast  = out_last_r;

  // Fill count never passes the capacity
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(CAPACITY))
    else $error("fill count above capacity");

  // An empty buffer has both pointers together
  a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == '0) |-> (rp_r == wp_r))
    else $error("pointers differ on empty buffer");

  // An overwrite leaves the buffer full
  a_over_full: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s1_over_r) |-> (s1_cnt_r == CW'(CAPACITY)))
    else $error("overwrite without full buffer");

  // A read result and an overwrite never come together
  a_read_xor_over: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r |-> !(s1_rd_r && s1_over_r))
    else $error("read and overwrite in one operation");

  // A stalled read stage keeps its item
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_move) |=> (s1_valid_r && $stable(s1_cnt_r)))
    else $error("read stage lost a stalled item");

endmodule

[hw/rtl/obrb_store.sv]
module obrb_store #(
  parameter int unsigned DEPTH = obrb_pkg::CAPACITY_DEF
) (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [$clog2(DEPTH)-1:0]   wr_addr,
  input  obrb_pkg::byte_t            wr_data,
  input  logic                       rd_en,
  input  logic [$clog2(DEPTH)-1:0]   rd_addr,
  output obrb_pkg::byte_t            rd_data
);
  import obrb_pkg::*;

  byte_t mem [DEPTH];
  byte_t rd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port, holds its data until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
